>>> sv/msx_pkg.sv
// ----------------------------------------------------------------------------
// msx_pkg
// Shared types and constants for the MIPS subset execute step.
// ----------------------------------------------------------------------------
package msx_pkg;

   localparam int unsigned MEM_BYTES_DEF = 65536;

   localparam logic [16:0] MEM_SIZE_RST = 17'd65536;
   localparam logic [31:0] RET_ADDR_RST = 32'h8123_456C;
   localparam logic [31:0] IN_ADDR_RST  = 32'hFFFF_0004;
   localparam logic [31:0] OUT_ADDR_RST = 32'hFFFF_000C;

   localparam logic [4:0]  LINK_REG     = 5'd31;
   localparam logic [4:0]  SP_REG       = 5'd30;
   localparam logic [31:0] SP_RST       = 32'd65536;

   typedef enum logic [4:0] {
      K_BAD   = 5'd0,
      K_ADD   = 5'd1,
      K_SUB   = 5'd2,
      K_MULT  = 5'd3,
      K_MULTU = 5'd4,
      K_DIV   = 5'd5,
      K_DIVU  = 5'd6,
      K_MFHI  = 5'd7,
      K_MFLO  = 5'd8,
      K_LIS   = 5'd9,
      K_LW    = 5'd10,
      K_SW    = 5'd11,
      K_SLT   = 5'd12,
      K_SLTU  = 5'd13,
      K_BEQ   = 5'd14,
      K_BNE   = 5'd15,
      K_JR    = 5'd16,
      K_JALR  = 5'd17
   } kind_type;

   typedef enum logic [1:0] {
      ST_CONT  = 2'd0,
      ST_FAULT = 2'd1,
      ST_OUT   = 2'd2,
      ST_HALT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_MEM_SIZE = 2'd0,
      CSR_RET_ADDR = 2'd1,
      CSR_IN_ADDR  = 2'd2,
      CSR_OUT_ADDR = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

endpackage

>>> sv/msx_regfile.sv
// ----------------------------------------------------------------------------
// msx_regfile
// General register file: one read port with registered data, one write
// port. Per-entry valid bits give the reset contents until first written.
// ----------------------------------------------------------------------------
module msx_regfile import msx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rd_addr,
   output logic [31:0] rd_data,
   input  rf_wr_type   wr
);

   logic [31:0] gpr_mem [32];
   logic [31:0] rdata_ff;
   logic [4:0]  raddr_ff;
   logic        rvld_ff;
   logic [31:0] vld_ff;
   logic [31:0] vld_in;

   always_ff @(posedge clock) begin
      if (wr.en && wr.addr != 5'd0) begin
         gpr_mem[wr.addr] <= wr.data;
      end
      rdata_ff <= gpr_mem[rd_addr];
      raddr_ff <= rd_addr;
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         rvld_ff <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      if (raddr_ff == 5'd0) begin
         rd_data = '0;
      end else if (rvld_ff) begin
         rd_data = rdata_ff;
      end else if (raddr_ff == SP_REG) begin
         rd_data = SP_RST;
      end else if (raddr_ff == LINK_REG) begin
         rd_data = RET_ADDR_RST;
      end else begin
         rd_data = '0;
      end
   end

endmodule

>>> sv/msx_dmem.sv
// ----------------------------------------------------------------------------
// msx_dmem
// Byte-wide data memory, one access a cycle (writes are ignored while busy), registered read data.
// Cleared byte by byte after reset while busy is high.
// ----------------------------------------------------------------------------
module msx_dmem import msx_pkg::*; #(
   parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
   localparam int unsigned AW = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata,
   output logic          busy
);

   logic [7:0]    mem [MEM_BYTES];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic          busy_ff;
   logic          busy_in;

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= 8'd0;
      end else if (en && we) begin
         mem[addr] <= wdata;
      end
      if (en) begin
         rdata_ff <= mem[addr];
      end
   end

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(MEM_BYTES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

>>> sv/msx_div.sv
// ----------------------------------------------------------------------------
// msx_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// done pulses for one cycle when quot and rem are ready.
// ----------------------------------------------------------------------------
module msx_div import msx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quot,
   output logic [31:0] rem
);

   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   assign trial = {1'b0, r_ff, q_ff[31]} - {2'b00, d_ff};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[33]) begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

>>> sv/mips_subset_execute_step.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_step
// Executes one decoded instruction of a small MIPS integer subset a beat.
//
// req_* carries one decoded instruction a beat; req_stall is high while an
// instruction is in flight and during the memory clearing pass.
// rsp_* carries status, output byte and next pc, one beat per instruction,
// held in an output register; a stalled response holds while the next
// instruction is taken and executed up to its final step.
// csr_* writes the four configuration registers; csr_ready is always high.
// Register ops, branches, jumps and divide by zero go through the read,
// execute and final states; mult/multu add a multiply state, lw/sw to memory
// a byte-wise memory state, div/divu a state that waits on the 32-step
// divider. One instruction is in flight at a time; the next request can be
// taken as soon as the response is raised. Reset: registers, hi/lo and pc
// take their reset values at once; the data memory is then cleared byte by
// byte, with requests stalled. Config writes are taken throughout.
// ----------------------------------------------------------------------------
module mips_subset_execute_step import msx_pkg::*; #(
   parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [4:0]        req_kind,
   input  logic [4:0]        req_rd,
   input  logic [4:0]        req_rs,
   input  logic [4:0]        req_rt,
   input  logic signed [15:0] req_imm,
   input  logic [31:0]       req_next_word,
   input  logic signed [8:0] req_in_char,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_out_byte,
   output logic [31:0]       rsp_next_pc,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   localparam int unsigned AW = $clog2(MEM_BYTES);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RDB  = 7'b0000010,
      S_EXEC = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_MEM  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [4:0]  rd_ff, rd_in, rt_ff, rt_in;
   logic [15:0] imm_ff, imm_in;
   logic [31:0] nword_ff, nword_in;
   logic [8:0]  ch_ff, ch_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] pc_ff, pc_in, hi_ff, hi_in, lo_ff, lo_in;
   rf_wr_type   wr_ff, wr_in;
   logic        hilo_we_ff, hilo_we_in;
   logic [31:0] hi_new_ff, hi_new_in, lo_new_ff, lo_new_in;
   status_type  status_ff, status_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic [31:0] npc_ff, npc_in;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [2:0]  mcnt_ff, mcnt_in;
   logic        mstore_ff, mstore_in;
   logic [23:0] word_ff, word_in;
   logic        sgn_q_ff, sgn_q_in, sgn_r_ff, sgn_r_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_obyte_ff, rsp_obyte_in;
   logic [31:0] rsp_npc_ff, rsp_npc_in;
   logic [16:0] msize_ff, msize_in;
   logic [31:0] ret_ff, ret_in, inad_ff, inad_in, outad_ff, outad_in;

   logic [4:0]  rf_raddr;
   logic [31:0] rf_rdata;
   rf_wr_type   rf_wr;
   logic        dm_en, dm_we, dm_busy;
   logic [AW-1:0] dm_addr;
   logic [7:0]  dm_wdata, dm_rdata;
   logic        div_start, div_done;
   logic [31:0] div_a, div_b, div_q, div_r;

   logic [32:0] lim, msz33, mem33;
   logic [31:0] pc4, pc8, maddr, br_tgt, bv;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic        sgn_div, fault;
   logic [31:0] bshift;

   msx_regfile u_rf (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata),
      .wr      (rf_wr)
   );

   msx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
      .clock (clock),
      .reset (reset),
      .en    (dm_en),
      .we    (dm_we),
      .addr  (dm_addr),
      .wdata (dm_wdata),
      .rdata (dm_rdata),
      .busy  (dm_busy)
   );

   msx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   assign msz33  = {16'd0, msize_ff};
   assign mem33  = 33'(MEM_BYTES);
   assign lim    = (msz33 < mem33) ? msz33 : mem33;
   assign pc4    = pc_ff + 32'd4;
   assign pc8    = pc_ff + 32'd8;
   assign maddr  = a_ff + {{16{imm_ff[15]}}, imm_ff};
   assign br_tgt = pc4 + {{14{imm_ff[15]}}, imm_ff, 2'b00};
   assign bv     = rf_rdata;
   assign sgn_div = (kind_ff == K_DIV);
   assign div_a  = (sgn_div && a_ff[31]) ? (32'd0 - a_ff) : a_ff;
   assign div_b  = (sgn_div && bv[31]) ? (32'd0 - bv) : bv;
   assign mul_a  = $signed({(kind_ff == K_MULT) & a_ff[31], a_ff});
   assign mul_b  = $signed({(kind_ff == K_MULT) & b_ff[31], b_ff});
   assign prod   = mul_a * mul_b;
   assign bshift = b_ff << {mcnt_ff[1:0], 3'b000};

   assign req_stall = (state_ff != S_IDLE) || dm_busy;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      rd_in         = rd_ff;
      rt_in         = rt_ff;
      imm_in        = imm_ff;
      nword_in      = nword_ff;
      ch_in         = ch_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pc_in         = pc_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      wr_in         = wr_ff;
      hilo_we_in    = hilo_we_ff;
      hi_new_in     = hi_new_ff;
      lo_new_in     = lo_new_ff;
      status_in     = status_ff;
      obyte_in      = obyte_ff;
      npc_in        = npc_ff;
      maddr_in      = maddr_ff;
      mcnt_in       = mcnt_ff;
      mstore_in     = mstore_ff;
      word_in       = word_ff;
      sgn_q_in      = sgn_q_ff;
      sgn_r_in      = sgn_r_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_obyte_in  = rsp_obyte_ff;
      rsp_npc_in    = rsp_npc_ff;
      msize_in      = msize_ff;
      ret_in        = ret_ff;
      inad_in       = inad_ff;
      outad_in      = outad_ff;
      rf_raddr      = req_rs;
      rf_wr         = '0;
      dm_en         = 1'b0;
      dm_we         = 1'b0;
      dm_addr       = maddr_ff + AW'(mcnt_ff);
      dm_wdata      = bshift[31:24];
      div_start     = 1'b0;
      fault         = 1'b0;

      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MEM_SIZE: msize_in = csr_data[16:0];
            CSR_RET_ADDR: ret_in   = csr_data;
            CSR_IN_ADDR:  inad_in  = csr_data;
            CSR_OUT_ADDR: outad_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               kind_in  = kind_type'(req_kind);
               rd_in    = req_rd;
               rt_in    = req_rt;
               imm_in   = req_imm;
               nword_in = req_next_word;
               ch_in    = req_in_char;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            a_in     = rf_rdata;
            rf_raddr = rt_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            b_in       = bv;
            wr_in      = '0;
            hilo_we_in = 1'b0;
            status_in  = ST_CONT;
            obyte_in   = 8'd0;
            npc_in     = pc4;
            state_in   = S_FIN;
            if ({1'b0, pc_ff} + 33'd4 > lim) begin
               fault = 1'b1;
            end else begin
               unique case (kind_ff)
                  K_ADD:  wr_in = '{en: 1'b1, addr: rd_ff, data: a_ff + bv};
                  K_SUB:  wr_in = '{en: 1'b1, addr: rd_ff, data: a_ff - bv};
                  K_MULT, K_MULTU: begin
                     hilo_we_in = 1'b1;
                     state_in   = S_MUL;
                  end
                  K_DIV, K_DIVU: begin
                     hilo_we_in = 1'b1;
                     if (bv == 32'd0) begin
                        hi_new_in = a_ff;
                        lo_new_in = '1;
                     end else begin
                        div_start = 1'b1;
                        sgn_q_in  = sgn_div && (a_ff[31] ^ bv[31]);
                        sgn_r_in  = sgn_div && a_ff[31];
                        state_in  = S_DIV;
                     end
                  end
                  K_MFHI: wr_in = '{en: 1'b1, addr: rd_ff, data: hi_ff};
                  K_MFLO: wr_in = '{en: 1'b1, addr: rd_ff, data: lo_ff};
                  K_LIS: begin
                     if ({1'b0, pc_ff} + 33'd8 > lim) begin
                        fault = 1'b1;
                     end else begin
                        wr_in  = '{en: 1'b1, addr: rd_ff, data: nword_ff};
                        npc_in = pc8;
                     end
                  end
                  K_LW: begin
                     if (maddr == inad_ff) begin
                        wr_in = '{en: 1'b1, addr: rt_ff, data: {{23{ch_ff[8]}}, ch_ff}};
                     end else if ({1'b0, maddr} + 33'd4 > lim) begin
                        fault = 1'b1;
                     end else begin
                        maddr_in  = maddr[AW-1:0];
                        mcnt_in   = 3'd0;
                        mstore_in = 1'b0;
                        state_in  = S_MEM;
                     end
                  end
                  K_SW: begin
                     if (maddr == outad_ff) begin
                        status_in = ST_OUT;
                        obyte_in  = bv[7:0];
                     end else if ({1'b0, maddr} + 33'd4 > lim) begin
                        fault = 1'b1;
                     end else begin
                        maddr_in  = maddr[AW-1:0];
                        mcnt_in   = 3'd0;
                        mstore_in = 1'b1;
                        state_in  = S_MEM;
                     end
                  end
                  K_SLT: wr_in = '{en: 1'b1, addr: rd_ff,
                                   data: {31'd0, $signed(a_ff) < $signed(bv)}};
                  K_SLTU: wr_in = '{en: 1'b1, addr: rd_ff, data: {31'd0, a_ff < bv}};
                  K_BEQ: begin
                     if (a_ff == bv) begin
                        npc_in = br_tgt;
                     end
                  end
                  K_BNE: begin
                     if (a_ff != bv) begin
                        npc_in = br_tgt;
                     end
                  end
                  K_JR: begin
                     npc_in = a_ff;
                     if (a_ff == ret_ff) begin
                        status_in = ST_HALT;
                     end
                  end
                  K_JALR: begin
                     wr_in  = '{en: 1'b1, addr: LINK_REG, data: pc4};
                     npc_in = a_ff;
                  end
                  default: fault = 1'b1;
               endcase
            end
            if (fault) begin
               wr_in      = '0;
               hilo_we_in = 1'b0;
               status_in  = ST_FAULT;
               obyte_in   = 8'd0;
               npc_in     = pc_ff;
               div_start  = 1'b0;
               state_in   = S_FIN;
            end
         end
         S_MUL: begin
            hi_new_in = prod[63:32];
            lo_new_in = prod[31:0];
            state_in  = S_FIN;
         end
         S_DIV: begin
            if (div_done) begin
               lo_new_in = sgn_q_ff ? (32'd0 - div_q) : div_q;
               hi_new_in = sgn_r_ff ? (32'd0 - div_r) : div_r;
               state_in  = S_FIN;
            end
         end
         S_MEM: begin
            dm_en   = (mcnt_ff != 3'd4);
            dm_we   = mstore_ff;
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff != 3'd0) begin
               word_in = {word_ff[15:0], dm_rdata};
            end
            if (mcnt_ff == 3'd4) begin
               if (!mstore_ff) begin
                  wr_in = '{en: 1'b1, addr: rt_ff, data: {word_ff, dm_rdata}};
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_obyte_in  = obyte_ff;
               rsp_npc_in    = npc_ff;
               pc_in         = npc_ff;
               rf_wr         = wr_ff;
               if (hilo_we_ff) begin
                  hi_in = hi_new_ff;
                  lo_in = lo_new_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      rd_ff      <= rd_in;
      rt_ff      <= rt_in;
      imm_ff     <= imm_in;
      nword_ff   <= nword_in;
      ch_ff      <= ch_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      hi_new_ff  <= hi_new_in;
      lo_new_ff  <= lo_new_in;
      obyte_ff   <= obyte_in;
      npc_ff     <= npc_in;
      status_ff  <= status_in;
      maddr_ff   <= maddr_in;
      mcnt_ff    <= mcnt_in;
      mstore_ff  <= mstore_in;
      word_ff    <= word_in;
      sgn_q_ff   <= sgn_q_in;
      sgn_r_ff   <= sgn_r_in;
      rsp_status_ff <= rsp_status_in;
      rsp_obyte_ff  <= rsp_obyte_in;
      rsp_npc_ff    <= rsp_npc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         wr_ff        <= '0;
         hilo_we_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         msize_ff     <= MEM_SIZE_RST;
         ret_ff       <= RET_ADDR_RST;
         inad_ff      <= IN_ADDR_RST;
         outad_ff     <= OUT_ADDR_RST;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         wr_ff        <= wr_in;
         hilo_we_ff   <= hilo_we_in;
         rsp_valid_ff <= rsp_valid_in;
         msize_ff     <= msize_in;
         ret_ff       <= ret_in;
         inad_ff      <= inad_in;
         outad_ff     <= outad_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_byte = rsp_obyte_ff;
   assign rsp_next_pc  = rsp_npc_ff;

endmodule
